/* sv/ber_value_content_decoder_unit_defines.svh */
// ----------------------------------------------------------------------------
// BER value content decoder assertion macros
// Shared concurrent assertion forms for the decoder unit.
// ----------------------------------------------------------------------------
`ifndef BER_VALUE_CONTENT_DECODER_UNIT_DEFINES_SVH
`define BER_VALUE_CONTENT_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define BVCD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define BVCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/ber_vcd_pkg.sv */
// ----------------------------------------------------------------------------
// BER value content decoder package
// Tag codes, widths and the item and result types shared by the decoder.
// ----------------------------------------------------------------------------
package ber_vcd_pkg;

   localparam int unsigned ELEMENT_WIDTH  = 32;
   localparam int unsigned OID_ARC_BASE   = 40;
   localparam int unsigned RSP_FIFO_DEPTH = 4;

   // SNMP tag codes.
   localparam logic [7:0] TAG_INTEGER      = 8'h02;
   localparam logic [7:0] TAG_OCTET_STRING = 8'h04;
   localparam logic [7:0] TAG_OID          = 8'h06;
   localparam logic [7:0] TAG_IP_ADDRESS   = 8'h40;
   localparam logic [7:0] TAG_COUNTER32    = 8'h41;
   localparam logic [7:0] TAG_GAUGE32      = 8'h42;
   localparam logic [7:0] TAG_TIMETICKS    = 8'h43;
   localparam logic [7:0] TAG_OPAQUE       = 8'h44;

   typedef struct packed {
      logic [7:0] tag;
      logic [7:0] data;
      logic       first;
      logic       last;
   } req_item_type;

   typedef struct packed {
      logic [ELEMENT_WIDTH-1:0] element;
      logic                     last;
      logic                     overflow;
   } result_type;

   // Up to two results produced by one transaction, r0 delivered first.
   typedef struct packed {
      logic [1:0] count;
      result_type r0;
      result_type r1;
   } result_pair_type;

endpackage

/* sv/ber_value_content_decoder_unit.sv */
// An accepted request byte is registered in the input stage; its results then go through the result queue.
// Throughput: one content byte per cycle while the queue has room for its results;
// the first OID subidentifier yields two results, which leave one after the other on the single result port.
// A 4-entry result queue lets requests keep flowing while results stall.
// Reset is synchronous and active high; it empties the input stage and the
// queue and clears the decoding state.
// ----------------------------------------------------------------------------
// BER value content decoder unit
// Decodes SNMP BER integer, OID and octet content bytes into 32-bit elements.
// ----------------------------------------------------------------------------
`include "ber_value_content_decoder_unit_defines.svh"

module ber_value_content_decoder_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [15:0]                            req_tdata,  // data_byte, first_byte, zero fill
   input  logic [7:0]                             req_tuser,  // req_type
   input  logic                                   req_tlast,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [ber_vcd_pkg::ELEMENT_WIDTH-1:0]  rsp_tdata,  // element
   output logic                                   rsp_tuser,  // overflow
   output logic                                   rsp_tlast
);

   localparam int unsigned CntW = $clog2(ber_vcd_pkg::RSP_FIFO_DEPTH + 1);

   logic                          in_valid_ff, in_valid_in;
   ber_vcd_pkg::req_item_type     in_item_ff;
   ber_vcd_pkg::result_pair_type  results;
   ber_vcd_pkg::result_type       head;
   logic [CntW-1:0]               fifo_space;
   logic                          fire;
   logic                          req_accept;

   // The held byte moves on once the queue has room for all its results.
   assign fire       = in_valid_ff && (fifo_space >= CntW'(results.count));
   assign req_tready = !in_valid_ff || fire;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff.tag   <= req_tuser;
         in_item_ff.data  <= req_tdata[7:0];
         in_item_ff.first <= req_tdata[8];
         in_item_ff.last  <= req_tlast;
      end
   end

   ber_vcd_core u_core (
      .clock   (clock),
      .reset   (reset),
      .item    (in_item_ff),
      .fire    (fire),
      .results (results)
   );

   ber_vcd_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_en    (fire),
      .push       (results),
      .space      (fifo_space),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .head       (head)
   );

   assign rsp_tdata = head.element;
   assign rsp_tlast = head.last;
   assign rsp_tuser = head.overflow;

   `BVCD_ASSERT_NOW(a_fire_fits, clock, reset, fire, CntW'(results.count) <= fifo_space, "result queue overrun")
   `BVCD_ASSERT_NOW(a_pair_is_oid, clock, reset, in_valid_ff && (results.count == 2'd2), (in_item_ff.tag == ber_vcd_pkg::TAG_OID) && !results.r0.last, "two results from a non-OID byte")
   `BVCD_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid && req_tready, "not empty after reset")

endmodule

/* sv/ber_vcd_rsp_fifo.sv */
// ----------------------------------------------------------------------------
// BER value content decoder result queue
// Small register queue that takes up to two results per cycle and delivers
// one per cycle on the result channel while it is ready.
// ----------------------------------------------------------------------------
module ber_vcd_rsp_fifo (
   input  logic                                                 clock,
   input  logic                                                 reset,
   input  logic                                                 push_en,
   input  ber_vcd_pkg::result_pair_type                         push,
   output logic [$clog2(ber_vcd_pkg::RSP_FIFO_DEPTH + 1)-1:0]   space,
   output logic                                                 rsp_tvalid,
   input  logic                                                 rsp_tready,
   output ber_vcd_pkg::result_type                              head
);

   localparam int unsigned Depth = ber_vcd_pkg::RSP_FIFO_DEPTH;
   localparam int unsigned PtrW  = $clog2(Depth);
   localparam int unsigned CntW  = $clog2(Depth + 1);

   ber_vcd_pkg::result_type mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [CntW-1:0] push_n;
   logic            pop;

   assign push_n     = push_en ? CntW'(push.count) : '0;
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];
   assign space      = CntW'(Depth) - count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + push_n[PtrW-1:0];
      rd_ptr_in = rd_ptr_ff + PtrW'(pop);
      count_in  = count_ff + push_n - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != '0) begin
         mem_ff[wr_ptr_ff] <= push.r0;
      end
      if (push_n == CntW'(2)) begin
         mem_ff[wr_ptr_ff + PtrW'(1)] <= push.r1;
      end
   end

endmodule

/* sv/ber_vcd_core.sv */
// ----------------------------------------------------------------------------
// BER value content decoder core
// Decodes one registered content byte against the running value state and
// produces zero, one or two results.
// ----------------------------------------------------------------------------
module ber_vcd_core (
   input  logic                          clock,
   input  logic                          reset,
   input  ber_vcd_pkg::req_item_type     item,
   input  logic                          fire,
   output ber_vcd_pkg::result_pair_type  results
);

   localparam int unsigned W = ber_vcd_pkg::ELEMENT_WIDTH;
   localparam logic [W-1:0] ArcStep1 = W'(ber_vcd_pkg::OID_ARC_BASE);
   localparam logic [W-1:0] ArcStep2 = W'(2 * ber_vcd_pkg::OID_ARC_BASE);

   logic [W-1:0] acc_ff, acc_in;
   logic         ovf_ff, ovf_in;
   logic         sign_ff, sign_in;
   logic         arc_pend_ff, arc_pend_in;

   logic         int_sign;
   logic [W-1:0] int_acc;
   logic         int_ovf;
   logic [W-1:0] oid_base;
   logic         oid_base_ovf;
   logic         oid_ovf;
   logic [W-1:0] oid_acc;
   logic         oid_pend;
   logic [1:0]   arc_hi;
   logic [W-1:0] arc_lo;

   // Integers: big-endian two's complement, sign taken from the first byte.
   assign int_sign = item.first ? item.data[7] : sign_ff;
   assign int_acc  = item.first ? {{(W-8){item.data[7]}}, item.data}
                                : {acc_ff[W-9:0], item.data};
   assign int_ovf  = item.first ? 1'b0
                   : (ovf_ff | (acc_ff[W-1 -: 8] != {8{sign_ff}})
                      | (sign_ff & ~int_acc[W-1]));

   // Object identifiers: base-128 arcs, seven bits per byte.
   assign oid_base     = item.first ? '0 : acc_ff;
   assign oid_base_ovf = item.first ? 1'b0 : ovf_ff;
   assign oid_ovf      = oid_base_ovf | (oid_base[W-1 -: 7] != '0);
   assign oid_acc      = {oid_base[W-8:0], item.data[6:0]};
   assign oid_pend     = item.first | arc_pend_ff;

   // The first subidentifier splits into two arcs; the upper arc saturates at 2.
   always_comb begin
      if (oid_acc >= ArcStep2) begin
         arc_hi = 2'd2;
         arc_lo = oid_acc - ArcStep2;
      end else if (oid_acc >= ArcStep1) begin
         arc_hi = 2'd1;
         arc_lo = oid_acc - ArcStep1;
      end else begin
         arc_hi = 2'd0;
         arc_lo = oid_acc;
      end
   end

   always_comb begin
      acc_in      = acc_ff;
      ovf_in      = ovf_ff;
      sign_in     = sign_ff;
      arc_pend_in = arc_pend_ff;
      results     = '0;
      unique case (item.tag) inside
         ber_vcd_pkg::TAG_INTEGER, ber_vcd_pkg::TAG_COUNTER32,
         ber_vcd_pkg::TAG_GAUGE32, ber_vcd_pkg::TAG_TIMETICKS: begin
            acc_in              = int_acc;
            ovf_in              = int_ovf;
            sign_in             = int_sign;
            results.count       = item.last ? 2'd1 : 2'd0;
            results.r0.element  = int_acc;
            results.r0.last     = 1'b1;
            results.r0.overflow = int_ovf;
         end
         ber_vcd_pkg::TAG_OID: begin
            if (!item.data[7]) begin
               acc_in      = '0;
               ovf_in      = 1'b0;
               arc_pend_in = 1'b0;
               if (oid_pend) begin
                  results.count       = 2'd2;
                  results.r0.element  = {{(W-2){1'b0}}, arc_hi};
                  results.r0.last     = 1'b0;
                  results.r0.overflow = oid_ovf;
                  results.r1.element  = arc_lo;
                  results.r1.last     = item.last;
                  results.r1.overflow = oid_ovf;
               end else begin
                  results.count       = 2'd1;
                  results.r0.element  = oid_acc;
                  results.r0.last     = item.last;
                  results.r0.overflow = oid_ovf;
               end
            end else if (item.last) begin
               // The value ended in the middle of an arc.
               acc_in              = '0;
               ovf_in              = 1'b0;
               arc_pend_in         = 1'b0;
               results.count       = 2'd1;
               results.r0.element  = oid_acc;
               results.r0.last     = 1'b1;
               results.r0.overflow = 1'b1;
            end else begin
               acc_in      = oid_acc;
               ovf_in      = oid_ovf;
               arc_pend_in = oid_pend;
            end
         end
         ber_vcd_pkg::TAG_OCTET_STRING, ber_vcd_pkg::TAG_IP_ADDRESS,
         ber_vcd_pkg::TAG_OPAQUE: begin
            results.count       = 2'd1;
            results.r0.element  = {{(W-8){1'b0}}, item.data};
            results.r0.last     = item.last;
            results.r0.overflow = 1'b0;
         end
         default: begin
            results.count = 2'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff      <= '0;
         ovf_ff      <= 1'b0;
         sign_ff     <= 1'b0;
         arc_pend_ff <= 1'b0;
      end else if (fire) begin
         acc_ff      <= acc_in;
         ovf_ff      <= ovf_in;
         sign_ff     <= sign_in;
         arc_pend_ff <= arc_pend_in;
      end
   end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// BER value content decoder testbench
// Streams SNMP integer, OID and octet content bytes into the decoder and
// checks every decoded element against a scoreboard that tracks the decoding
// state on its own. A directed pass covers the corner values, then random
// values run under several idle and stall patterns and one long output hold.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int unsigned PHASE_ITEMS     = 310;
   localparam int unsigned HOLD_OFF_CYCLES = 500;
   localparam int unsigned WATCHDOG_LIMIT  = 3000;
   localparam int unsigned DRAIN_CYCLES    = 20;

   // A constructed tag that the decoder does not know.
   localparam logic [7:0] TAG_SEQUENCE = 8'h30;

   typedef logic [7:0] content_bytes_type[$];

   // Tracks the decoding state and holds the elements still to come out.
   class decoder_scoreboard;
      ber_vcd_pkg::result_type element_q[$];
      int unsigned error_count;
      logic [31:0] acc;
      logic        acc_overflow;
      logic        int_negative;
      logic        arc_split_pending;

      function new();
         error_count       = 0;
         acc               = '0;
         acc_overflow      = 1'b0;
         int_negative      = 1'b0;
         arc_split_pending = 1'b0;
      endfunction

      function void push(logic [31:0] element, logic last, logic overflow);
         ber_vcd_pkg::result_type r;
         r.element  = element;
         r.last     = last;
         r.overflow = overflow;
         element_q.push_back(r);
      endfunction

      function void note_request(ber_vcd_pkg::req_item_type item);
         logic [31:0] top_arc;
         case (item.tag) inside
            ber_vcd_pkg::TAG_INTEGER, ber_vcd_pkg::TAG_COUNTER32,
            ber_vcd_pkg::TAG_GAUGE32, ber_vcd_pkg::TAG_TIMETICKS: begin
               if (item.first) begin
                  int_negative = item.data[7];
                  acc          = {{24{item.data[7]}}, item.data};
                  acc_overflow = 1'b0;
               end else begin
                  // Bits shifted out must all be copies of the sign.
                  if (acc[31:24] != {8{int_negative}})
                     acc_overflow = 1'b1;
                  acc = {acc[23:0], item.data};
                  if (int_negative && !acc[31])
                     acc_overflow = 1'b1;
               end
               if (item.last)
                  push(acc, 1'b1, acc_overflow);
            end
            ber_vcd_pkg::TAG_OID: begin
               if (item.first) begin
                  acc               = '0;
                  acc_overflow      = 1'b0;
                  arc_split_pending = 1'b1;
               end
               if (acc[31:25] != '0)
                  acc_overflow = 1'b1;
               acc = {acc[24:0], item.data[6:0]};
               if (!item.data[7]) begin
                  if (arc_split_pending) begin
                     // The first subidentifier carries two arcs.
                     top_arc = acc / ber_vcd_pkg::OID_ARC_BASE;
                     if (top_arc > 2)
                        top_arc = 2;
                     push(top_arc, 1'b0, acc_overflow);
                     push(acc - ber_vcd_pkg::OID_ARC_BASE * top_arc, item.last,
                          acc_overflow);
                     arc_split_pending = 1'b0;
                  end else begin
                     push(acc, item.last, acc_overflow);
                  end
                  acc          = '0;
                  acc_overflow = 1'b0;
               end else if (item.last) begin
                  // The value stopped in the middle of an arc.
                  push(acc, 1'b1, 1'b1);
                  acc               = '0;
                  acc_overflow      = 1'b0;
                  arc_split_pending = 1'b0;
               end
            end
            ber_vcd_pkg::TAG_OCTET_STRING, ber_vcd_pkg::TAG_IP_ADDRESS,
            ber_vcd_pkg::TAG_OPAQUE:
               push({24'h0, item.data}, item.last, 1'b0);
            default: ;
         endcase
      endfunction

      task report(string msg);
         $display("MISMATCH @%0t: %s", $realtime, msg);
         error_count++;
      endtask

      task check_result(logic [31:0] element, logic last, logic overflow);
         ber_vcd_pkg::result_type want;
         if (element_q.size() == 0) begin
            report($sformatf("unexpected element %h last %b overflow %b",
                             element, last, overflow));
            return;
         end
         want = element_q.pop_front();
         if (element !== want.element)
            report($sformatf("element %h, expected %h", element, want.element));
         if (last !== want.last)
            report($sformatf("last %b, expected %b (element %h)",
                             last, want.last, want.element));
         if (overflow !== want.overflow)
            report($sformatf("overflow %b, expected %b (element %h)",
                             overflow, want.overflow, want.element));
      endtask

      function int unsigned outstanding();
         return element_q.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // data_byte, first_byte, zero fill
   logic [7:0]  req_tuser;   // req_type
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [ber_vcd_pkg::ELEMENT_WIDTH-1:0] rsp_tdata;  // element
   logic        rsp_tuser;   // overflow
   logic        rsp_tlast;

   logic        rsp_hold = 1'b0;
   bit          pressure_go = 1'b0;
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned counted_items = 0;
   int unsigned idle_cycles = 0;
   decoder_scoreboard board;

   ber_value_content_decoder_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= !rsp_hold && ($urandom_range(99) >= rsp_stall_pct);
   end

   // Long output hold while the sender keeps pushing, so the queue fills up.
   initial begin
      wait (pressure_go);
      rsp_hold <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_result(rsp_tdata, rsp_tlast, rsp_tuser);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_byte(input logic [7:0] tag, input logic [7:0] data,
                            input logic first, input logic last);
      ber_vcd_pkg::req_item_type item;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= tag;
      req_tdata  <= {7'b0, first, data};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      item.tag   = tag;
      item.data  = data;
      item.first = first;
      item.last  = last;
      board.note_request(item);
      case (tag) inside
         ber_vcd_pkg::TAG_INTEGER, ber_vcd_pkg::TAG_COUNTER32,
         ber_vcd_pkg::TAG_GAUGE32, ber_vcd_pkg::TAG_TIMETICKS, ber_vcd_pkg::TAG_OID,
         ber_vcd_pkg::TAG_OCTET_STRING, ber_vcd_pkg::TAG_IP_ADDRESS,
         ber_vcd_pkg::TAG_OPAQUE: counted_items++;
         default: ;
      endcase
   endtask

   task automatic send_value(input logic [7:0] tag, input content_bytes_type content);
      foreach (content[i])
         send_byte(tag, content[i], i == 0, i == content.size() - 1);
   endtask

   task automatic send_random_value();
      content_bytes_type content;
      logic [7:0]     tag;
      int unsigned    arc_count;
      int unsigned    arc_len;
      int unsigned    pick;
      pick = $urandom_range(99);
      if (pick < 30) begin
         case ($urandom_range(3))
            0: tag = ber_vcd_pkg::TAG_INTEGER;
            1: tag = ber_vcd_pkg::TAG_COUNTER32;
            2: tag = ber_vcd_pkg::TAG_GAUGE32;
            default: tag = ber_vcd_pkg::TAG_TIMETICKS;
         endcase
         arc_len = ($urandom_range(9) < 7) ? $urandom_range(1, 4) : $urandom_range(5, 7);
         // Lead with sign-edge bytes often so both range limits get hit.
         case ($urandom_range(4))
            0: content.push_back(8'h00);
            1: content.push_back(8'hFF);
            2: content.push_back(8'h7F);
            3: content.push_back(8'h80);
            default: content.push_back(8'($urandom_range(255)));
         endcase
         repeat (arc_len - 1) content.push_back(8'($urandom_range(255)));
         send_value(tag, content);
      end else if (pick < 60) begin
         arc_count = $urandom_range(1, 6);
         repeat (arc_count) begin
            arc_len = ($urandom_range(9) < 7) ? $urandom_range(1, 2) : $urandom_range(3, 6);
            for (int k = 0; k < arc_len; k++)
               content.push_back({k < arc_len - 1, 7'($urandom_range(127))});
         end
         if ($urandom_range(9) == 0)
            content.push_back({1'b1, 7'($urandom_range(127))});
         send_value(ber_vcd_pkg::TAG_OID, content);
      end else if (pick < 80) begin
         case ($urandom_range(2))
            0: tag = ber_vcd_pkg::TAG_OCTET_STRING;
            1: tag = ber_vcd_pkg::TAG_IP_ADDRESS;
            default: tag = ber_vcd_pkg::TAG_OPAQUE;
         endcase
         repeat ($urandom_range(1, 8)) content.push_back(8'($urandom_range(255)));
         send_value(tag, content);
      end else if (pick < 92) begin
         // Broken framing: known tags with arbitrary first and last marks.
         case ($urandom_range(3))
            0: tag = ber_vcd_pkg::TAG_INTEGER;
            1: tag = ber_vcd_pkg::TAG_OID;
            2: tag = ber_vcd_pkg::TAG_TIMETICKS;
            default: tag = ber_vcd_pkg::TAG_OCTET_STRING;
         endcase
         repeat ($urandom_range(1, 4))
            send_byte(tag, 8'($urandom_range(255)), 1'($urandom_range(1)),
                      1'($urandom_range(1)));
      end else begin
         repeat ($urandom_range(1, 3))
            send_byte(8'($urandom_range(255)), 8'($urandom_range(255)),
                      1'($urandom_range(1)), 1'($urandom_range(1)));
      end
   endtask

   initial begin
      int unsigned phase_start;
      board      = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      req_tlast  = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed corner cases.
      send_value(ber_vcd_pkg::TAG_INTEGER, '{8'h00});
      send_value(ber_vcd_pkg::TAG_COUNTER32, '{8'hFF});
      // Unsigned value with a leading zero byte still fits in 32 bits.
      send_value(ber_vcd_pkg::TAG_GAUGE32, '{8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
      // First arc split plus a two-byte arc.
      send_value(ber_vcd_pkg::TAG_OID, '{8'h2B, 8'h06, 8'h81, 8'h00});
      // Large first subidentifier caps the top arc, then the value ends mid-arc.
      send_value(ber_vcd_pkg::TAG_OID, '{8'hFF, 8'h7F, 8'h88});
      // An arc that fills all 32 bits of the element without overflow.
      send_value(ber_vcd_pkg::TAG_OID, '{8'h50, 8'h8F, 8'hFF, 8'hFF, 8'hFF, 8'h7F});
      send_value(ber_vcd_pkg::TAG_OCTET_STRING, '{8'h00});
      send_value(ber_vcd_pkg::TAG_IP_ADDRESS, '{8'hFF});
      send_value(ber_vcd_pkg::TAG_OPAQUE, '{8'hA5});
      send_byte(TAG_SEQUENCE, 8'h5A, 1'b1, 1'b1);
      // Continuation with no first mark picks up the current state.
      send_byte(ber_vcd_pkg::TAG_TIMETICKS, 8'h12, 1'b0, 1'b1);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
               pressure_go   = 1'b1;
            end
            1: begin
               send_idle_pct = 65;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 65;
            end
            default: begin
               send_idle_pct = 7;
               rsp_stall_pct = 7;
            end
         endcase
         phase_start = counted_items;
         while (counted_items - phase_start < PHASE_ITEMS)
            send_random_value();
      end
      req_tvalid <= 1'b0;

      while (board.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

/* files.f */
+incdir+sv
sv/ber_vcd_pkg.sv
sv/ber_vcd_rsp_fifo.sv
sv/ber_vcd_core.sv
sv/ber_value_content_decoder_unit.sv
dv/tb_top.sv
